@@ design/mau_pkg.sv @@
// ----------------------------------------------------------------------------
// Matrix arithmetic unit package
// Shared constants, codes and beat types for the matrix arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none
package mau_pkg;
    localparam int MAX_DIM_DEF   = 4;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int DIM_W         = 3;
    localparam int CFG_IDX_W     = 2;

    localparam logic [1:0] KIND_LOAD_A = 2'd0;
    localparam logic [1:0] KIND_LOAD_B = 2'd1;
    localparam logic [1:0] KIND_START  = 2'd2;

    localparam logic [2:0] OP_MUL   = 3'd0;
    localparam logic [2:0] OP_ADD   = 3'd1;
    localparam logic [2:0] OP_SUB   = 3'd2;
    localparam logic [2:0] OP_SCALE = 3'd3;
    localparam logic [2:0] OP_DIV   = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_SIZE    = 2'd1;
    localparam logic [1:0] ST_DIVZERO = 2'd2;

    localparam logic [1:0] CFG_A_ROWS = 2'd0;
    localparam logic [1:0] CFG_A_COLS = 2'd1;
    localparam logic [1:0] CFG_B_ROWS = 2'd2;
    localparam logic [1:0] CFG_B_COLS = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic [1:0]         row;
        logic [1:0]         col;
        logic signed [31:0] value;
        logic [2:0]         op;
        logic signed [31:0] scalar;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]         row_res;
        logic [1:0]         col_res;
        logic signed [31:0] value_res;
        logic               last;
        logic [1:0]         status;
        logic               saturated;
    } t_out_beat;

    // Divider handshake.
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_div_ctl;
endpackage
`default_nettype wire

@@ design/mau_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module mau_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ design/mau_div.sv @@
// ----------------------------------------------------------------------------
// Fixed-point divider
// Restoring divider, one quotient bit per cycle: (a << FRAC_BITS) / d,
// truncated toward zero, saturated to the signed 32-bit range.
// ----------------------------------------------------------------------------
`default_nettype none
module mau_div #(
    parameter int FRAC_BITS = mau_pkg::FRAC_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic signed [31:0]  i_num,
    input  wire logic signed [31:0]  i_den,
    output mau_pkg::t_div_ctl        o_ctl,
    output logic signed [31:0]       o_quot,
    output logic                     o_sat
);
    localparam int NW  = 32 + FRAC_BITS;
    localparam int CW  = $clog2(NW + 1);

    logic [NW-1:0] r_q;
    logic [32:0]   r_rem;
    logic [31:0]   r_den;
    logic          r_neg;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [33:0]   w_trial;
    logic [NW:0]   w_mag;

    assign w_trial = {r_rem, r_q[NW-1]} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
                r_neg  <= i_num[31] ^ i_den[31];
                r_rem  <= '0;
                r_q    <= {(i_num[31] ? 32'(-i_num) : 32'(i_num)), {FRAC_BITS{1'b0}}};
                r_den  <= i_den[31] ? 32'(-i_den) : 32'(i_den);
            end else if (r_busy) begin
                if (!w_trial[33]) begin
                    r_rem <= w_trial[32:0];
                    r_q   <= {r_q[NW-2:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[31:0], r_q[NW-1]};
                    r_q   <= {r_q[NW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Quotient magnitude to signed, with clipping.
    always_comb begin
        w_mag  = {1'b0, r_q};
        o_sat  = 1'b0;
        o_quot = '0;
        if (r_neg) begin
            if (w_mag > (NW+1)'(33'h080000000)) begin
                o_sat  = 1'b1;
                o_quot = 32'sh80000000;
            end else begin
                o_quot = 32'(-w_mag);
            end
        end else if (w_mag > (NW+1)'(32'h7fffffff)) begin
            o_sat  = 1'b1;
            o_quot = 32'sh7fffffff;
        end else begin
            o_quot = 32'(w_mag);
        end
    end

    assign o_ctl = '{start: i_start, busy: r_busy, done: r_done};
endmodule
`default_nettype wire

@@ design/matrix_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// Matrix arithmetic unit
// Loads A and B in Q16.16, then runs multiply, add, subtract, scale or
// divide and streams the result row-major.
//
// Input channel (i_valid/o_ready) carries load beats and start beats.
// A load beat writes one element of A or B.
// A start beat with a valid op code runs one operation and streams its
// result elements on the output channel (o_valid/i_ready), last set on the
// final element; an operation error gives a single beat with nonzero status.
// Elements are read from two RAMs with registered reads. For each element
// the sequencer issues a read, waits for the registered data, then computes:
//   multiply: one multiply-accumulate per inner index; add, subtract and
//   scale: one sum, difference or product; divide: the serial divider.
//   The block takes no new beat until the last result is taken.
// A stalled receiver holds the output register and pauses the sequencer.
// Reset returns the dimension registers to 4 and the sequencer to idle;
// RAM contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module matrix_arithmetic_unit #(
    parameter int MAX_DIM   = mau_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = mau_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire mau_pkg::t_in_beat           i_data,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output mau_pkg::t_out_beat               o_data,
    input  wire logic                        i_cfg_we,
    input  wire logic [mau_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [mau_pkg::DIM_W-1:0]   i_cfg_data
);
    localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int AW = $clog2(MAX_DIM * MAX_DIM) > 0 ? $clog2(MAX_DIM * MAX_DIM) : 1;
    localparam int DEPTH = MAX_DIM * MAX_DIM;

    typedef enum logic [2:0] {S_IDLE, S_READ, S_WAIT, S_CALC, S_DIVW, S_OUT} t_state;

    t_state r_state;
    logic [mau_pkg::DIM_W-1:0] r_dim [4];
    logic [2:0]  r_op;
    logic signed [31:0] r_scalar;
    logic [IW-1:0] r_i, r_j, r_k;
    logic [3:0]  r_nr, r_nc, r_nk;
    logic signed [69:0] r_acc;
    logic signed [63:0] r_prod;
    logic        r_pv;
    logic        r_in_ready;

    logic signed [31:0] w_a, w_b;
    logic        w_we_a, w_we_b;
    logic [AW-1:0] w_waddr, w_ra, w_rb;
    logic [IW-1:0] w_kr;
    logic [3:0]  w_ar, w_ac, w_br, w_bc;
    logic        w_acc_in;
    mau_pkg::t_div_ctl w_dctl;
    logic signed [31:0] w_quot;
    logic        w_dsat;
    logic        w_div_start;
    logic signed [69:0] w_sum;
    logic        w_lastk;

    function automatic logic [3:0] dim_of(input logic [mau_pkg::DIM_W-1:0] v);
        logic [3:0] d;
        d = {1'b0, v};
        if (d == 4'd0) d = 4'd1;
        if (d > 4'(MAX_DIM)) d = 4'(MAX_DIM);
        return d;
    endfunction

    assign w_ar = dim_of(r_dim[mau_pkg::CFG_A_ROWS]);
    assign w_ac = dim_of(r_dim[mau_pkg::CFG_A_COLS]);
    assign w_br = dim_of(r_dim[mau_pkg::CFG_B_ROWS]);
    assign w_bc = dim_of(r_dim[mau_pkg::CFG_B_COLS]);

    assign o_ready  = r_in_ready;
    assign w_acc_in = i_valid && r_in_ready;

    // Loads inside the store write directly; indices at or beyond MAX_DIM are dropped.
    always_comb begin
        w_waddr = AW'({i_data.row, i_data.col} >> 0);
        w_waddr = AW'(32'(i_data.row) * MAX_DIM + 32'(i_data.col));
        w_we_a = w_acc_in && i_data.kind == mau_pkg::KIND_LOAD_A
                 && 32'(i_data.row) < MAX_DIM && 32'(i_data.col) < MAX_DIM;
        w_we_b = w_acc_in && i_data.kind == mau_pkg::KIND_LOAD_B
                 && 32'(i_data.row) < MAX_DIM && 32'(i_data.col) < MAX_DIM;
        // While accumulating, the read runs one inner index ahead of the data.
        w_kr = (r_state == S_WAIT) ? r_k + 1'b1 : r_k;
        if (r_op == mau_pkg::OP_MUL) begin
            w_ra = AW'(32'(r_i) * MAX_DIM + 32'(w_kr));
            w_rb = AW'(32'(w_kr) * MAX_DIM + 32'(r_j));
        end else begin
            w_ra = AW'(32'(r_i) * MAX_DIM + 32'(r_j));
            w_rb = w_ra;
        end
    end

    mau_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_a (
        .i_clk(i_clk), .i_we(w_we_a), .i_waddr(w_waddr), .i_wdata(i_data.value),
        .i_raddr(w_ra), .o_rdata(w_a)
    );
    mau_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_b (
        .i_clk(i_clk), .i_we(w_we_b), .i_waddr(w_waddr), .i_wdata(i_data.value),
        .i_raddr(w_rb), .o_rdata(w_b)
    );

    assign w_div_start = (r_state == S_CALC) && (r_op == mau_pkg::OP_DIV)
                         && (!o_valid || i_ready);

    mau_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_num(w_a), .i_den(r_scalar), .o_ctl(w_dctl), .o_quot(w_quot), .o_sat(w_dsat)
    );

    assign w_sum = r_acc + 70'(r_prod >>> FRAC_BITS);
    assign w_lastk = ({1'b0, r_k} + 1'b1) == 5'(r_nk);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b0;
            o_valid    <= 1'b0;
            r_pv       <= 1'b0;
            for (int n = 0; n < 4; n++) r_dim[n] <= 3'd4;
        end else begin
            if (i_cfg_we) r_dim[i_cfg_idx] <= i_cfg_data;
            if (o_valid && i_ready) o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    r_in_ready <= 1'b1;
                    if (w_acc_in && i_data.kind == mau_pkg::KIND_START
                        && i_data.op <= mau_pkg::OP_DIV) begin
                        r_in_ready <= 1'b0;
                        r_op     <= i_data.op;
                        r_scalar <= i_data.scalar;
                        r_i <= '0; r_j <= '0; r_k <= '0;
                        r_nr <= w_ar;
                        r_nc <= (i_data.op == mau_pkg::OP_MUL) ? w_bc : w_ac;
                        r_nk <= w_ac;
                        o_data <= '0;
                        if ((i_data.op == mau_pkg::OP_MUL && w_ac != w_br) ||
                            ((i_data.op == mau_pkg::OP_ADD || i_data.op == mau_pkg::OP_SUB)
                             && (w_ar != w_br || w_ac != w_bc))) begin
                            o_data.last   <= 1'b1;
                            o_data.status <= mau_pkg::ST_SIZE;
                            r_state       <= S_OUT;
                        end else if (i_data.op == mau_pkg::OP_DIV && i_data.scalar == 0) begin
                            o_data.last   <= 1'b1;
                            o_data.status <= mau_pkg::ST_DIVZERO;
                            r_state       <= S_OUT;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_acc   <= '0;
                    r_pv    <= 1'b0;
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    // Multiply: RAM data for r_k is valid now; register the product.
                    if (r_op == mau_pkg::OP_MUL) begin
                        r_prod <= w_a * w_b;
                        if (r_pv) r_acc <= w_sum;
                        r_pv <= 1'b1;
                        if (w_lastk) begin
                            r_state <= S_CALC;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end else if (r_op == mau_pkg::OP_SCALE) begin
                        r_prod  <= w_a * r_scalar;
                        r_state <= S_CALC;
                    end else begin
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    // The output register must be free before its next value is built.
                    if (!o_valid || i_ready) begin
                        if (r_op != mau_pkg::OP_DIV) begin
                            case (r_op)
                                mau_pkg::OP_MUL:   r_acc <= w_sum;
                                mau_pkg::OP_ADD:   r_acc <= 70'(w_a) + 70'(w_b);
                                mau_pkg::OP_SUB:   r_acc <= 70'(w_a) - 70'(w_b);
                                default:           r_acc <= 70'(r_prod >>> FRAC_BITS);
                            endcase
                        end
                        r_state <= S_DIVW;
                    end
                end
                S_DIVW: begin
                    if (r_op != mau_pkg::OP_DIV || w_dctl.done) begin
                        o_data.row_res <= 2'(r_i);
                        o_data.col_res <= 2'(r_j);
                        o_data.status  <= mau_pkg::ST_OK;
                        o_data.last    <= (5'(r_i) + 1'b1 == 5'(r_nr))
                                          && (5'(r_j) + 1'b1 == 5'(r_nc));
                        if (r_op == mau_pkg::OP_DIV) begin
                            o_data.value_res <= w_quot;
                            o_data.saturated <= w_dsat;
                        end else if (r_acc > 70'sh7fffffff) begin
                            o_data.value_res <= 32'sh7fffffff;
                            o_data.saturated <= 1'b1;
                        end else if (r_acc < -70'sh80000000) begin
                            o_data.value_res <= 32'sh80000000;
                            o_data.saturated <= 1'b1;
                        end else begin
                            o_data.value_res <= 32'(r_acc);
                            o_data.saturated <= 1'b0;
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // Output register is free here; present the beat and step on.
                    if (!o_valid) begin
                        o_valid <= 1'b1;
                        r_k <= '0;
                        if (o_data.last) begin
                            r_state <= S_IDLE;
                        end else if (5'(r_j) + 1'b1 == 5'(r_nc)) begin
                            r_j <= '0;
                            r_i <= r_i + 1'b1;
                            r_state <= S_READ;
                        end else begin
                            r_j <= r_j + 1'b1;
                            r_state <= S_READ;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            // Hold new beats off until the final result has been taken.
            if (r_state == S_IDLE && o_valid && !i_ready) r_in_ready <= 1'b0;
        end
    end

    logic w_unused;
    assign w_unused = w_dctl.start ^ w_dctl.busy;
endmodule
`default_nettype wire

@@ design/mau_checker.sv @@
// ----------------------------------------------------------------------------
// Matrix arithmetic unit checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module mau_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_ready,
    input wire logic               o_valid,
    input wire logic               i_ready,
    input wire mau_pkg::t_out_beat o_data
);
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("output beat changed under stall");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status != mau_pkg::ST_OK |-> o_data.last)
        else $error("error beat without last");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status != mau_pkg::ST_OK |-> o_data.value_res == 0
        && !o_data.saturated)
        else $error("error beat carries data");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid && !o_ready)
        else $error("handshake active after reset");
endmodule

bind matrix_arithmetic_unit mau_checker u_mau_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready), .o_valid(o_valid),
    .i_ready(i_ready), .o_data(o_data)
);
`default_nettype wire
